// ----- src/spq_pkg.sv -----
// Shared types, sizes and helper functions for the stable priority task queue.
// Used by spq_cell and stable_priority_task_queue; depends on nothing else.

package spq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOT_W      = 7;
    localparam int CMP_W       = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam int TAG_W   = 16;
    localparam int PRIO_W  = 3;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int OUT_CNT_W = 8;

    localparam logic [YEAR_W-1:0]  MIN_YEAR_RST = 12'd2024;
    localparam logic [PRIO_W-1:0]  PRIO_MIN     = 3'd1;
    localparam logic [PRIO_W-1:0]  PRIO_MAX     = 3'd5;
    localparam logic [DAY_W-1:0]   DAY_LEAP_FEB = 5'd29;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAX    = 4'd12;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_COMPLETE = 2'd1,
        ACT_PEEK     = 2'd2,
        ACT_NONE     = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [PRIO_W-1:0]  prio;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry entry;
    } t_cell_cmd;

    typedef struct packed {
        logic occ;
        logic at_free;
        logic hit;
        logic from_idx;
    } t_cell_pos;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                      len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic date_ok(
        input logic [DAY_W-1:0]   day,
        input logic [MONTH_W-1:0] month,
        input logic [YEAR_W-1:0]  year,
        input logic [YEAR_W-1:0]  min_year
    );
        logic ok;
        if (year < min_year || month == '0 || month > MONTH_MAX) begin
            ok = 1'b0;
        end else if (month == MONTH_FEB && year[1:0] == 2'b00) begin
            ok = (day <= DAY_LEAP_FEB);
        end else begin
            ok = (day <= month_len(month));
        end
        return ok;
    endfunction

endpackage

// ----- src/spq_cell.sv -----
// One slot of the sorted entry chain: holds an entry and shifts it toward either neighbor.
// Depends on spq_pkg for the entry, command and position types.

module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  spq_pkg::t_cell_pos i_pos,
    input  spq_pkg::t_entry    i_left_entry,
    input  logic               i_left_move,
    input  spq_pkg::t_entry    i_right_entry,
    output spq_pkg::t_entry    o_entry,
    output spq_pkg::t_entry    o_next,
    output logic               o_move,
    output logic [spq_pkg::TAG_W-1:0] o_hit_tag
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    assign o_move = i_pos.at_free || (i_pos.occ && (r_entry.prio > i_cmd.entry.prio));

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            spq_pkg::OP_INSERT: begin
                if (o_move) begin
                    n_entry = i_left_move ? i_left_entry : i_cmd.entry;
                end
            end
            spq_pkg::OP_REMOVE: begin
                if (i_pos.from_idx) begin
                    n_entry = i_right_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry   = r_entry;
    assign o_next    = n_entry;
    assign o_hit_tag = i_pos.hit ? r_entry.tag : '0;

endmodule

// ----- src/stable_priority_task_queue.sv -----
// Top level of the stable priority task queue: stream ports, command decode and cell chain.
// Depends on spq_pkg and spq_cell.

// The queue keeps up to QUEUE_DEPTH pending tasks sorted by priority (1 served first, ties in
// arrival order) in a chain of cells, one entry per cell. An add, complete or peek transaction
// is taken whole: each cell decides locally whether to keep its entry or take its left or right
// neighbor's, so the table shifts at once and one transaction per cycle is sustained while
// results are drained. Each transaction yields exactly one result transaction, registered in
// the cycle after it is taken, carrying the accept flag, the removed tag, the new head entry and
// the count. The input side stays ready while the output register is empty or being drained.
// The minimum accepted due year is written through i_cfg_we / i_cfg_wdata and resets to 2024.

module stable_priority_task_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [spq_pkg::YEAR_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // tdata, lowest bit up: task_tag, priority_req, due_day, due_month, due_year,
    // slot_index, zero fill
    input  logic [spq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // tuser: action
    input  logic [spq_pkg::S_TUSER_W-1:0]   i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tdata, lowest bit up: accepted, removed_tag, head_valid, head_tag, head_priority,
    // head_day, head_month, head_year, pending_count, zero fill
    output logic [spq_pkg::M_TDATA_W-1:0]   o_m_tdata
);

    localparam int DEPTH = spq_pkg::QUEUE_DEPTH;

    logic [spq_pkg::YEAR_W-1:0] r_min_year;
    logic [spq_pkg::CNT_W-1:0]  r_count;
    logic [spq_pkg::CNT_W-1:0]  n_count;
    logic                       r_m_valid;
    logic [spq_pkg::M_TDATA_W-1:0] r_m_data;
    logic [spq_pkg::M_TDATA_W-1:0] n_m_data;

    logic               s_accept;
    spq_pkg::t_action   act;
    spq_pkg::t_entry    in_entry;
    logic [spq_pkg::SLOT_W-1:0] slot;
    logic [spq_pkg::CMP_W-1:0]  slot_ext;
    logic [spq_pkg::CMP_W-1:0]  count_ext;
    logic               add_ok;
    logic               rem_ok;
    logic               acc_flag;
    spq_pkg::t_cell_cmd cmd;

    spq_pkg::t_entry    w_entry [DEPTH];
    spq_pkg::t_entry    w_next  [DEPTH];
    logic               w_move  [DEPTH];
    logic [spq_pkg::TAG_W-1:0] w_hit_tag [DEPTH];
    logic [spq_pkg::TAG_W-1:0] hit_tag_or;
    logic [spq_pkg::TAG_W-1:0] removed_tag;
    spq_pkg::t_entry    head;
    logic               head_valid;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign act            = spq_pkg::t_action'(i_s_tuser);
    assign in_entry.tag   = i_s_tdata[15:0];
    assign in_entry.prio  = i_s_tdata[18:16];
    assign in_entry.day   = i_s_tdata[23:19];
    assign in_entry.month = i_s_tdata[27:24];
    assign in_entry.year  = i_s_tdata[39:28];
    assign slot           = i_s_tdata[46:40];

    assign slot_ext  = spq_pkg::CMP_W'(slot);
    assign count_ext = spq_pkg::CMP_W'(r_count);

    assign add_ok = (r_count < spq_pkg::CNT_W'(DEPTH))
                 && (in_entry.prio >= spq_pkg::PRIO_MIN)
                 && (in_entry.prio <= spq_pkg::PRIO_MAX)
                 && spq_pkg::date_ok(in_entry.day, in_entry.month, in_entry.year, r_min_year);
    assign rem_ok = (slot_ext < count_ext);

    always_comb begin
        cmd.entry = in_entry;
        cmd.op    = spq_pkg::OP_HOLD;
        acc_flag  = 1'b0;
        n_count   = r_count;
        unique case (act)
            spq_pkg::ACT_ADD: begin
                if (add_ok) begin
                    cmd.op   = spq_pkg::OP_INSERT;
                    acc_flag = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            spq_pkg::ACT_COMPLETE: begin
                if (rem_ok) begin
                    cmd.op   = spq_pkg::OP_REMOVE;
                    acc_flag = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            spq_pkg::ACT_PEEK: begin
                acc_flag = 1'b1;
            end
            default: begin
                acc_flag = 1'b0;
            end
        endcase
        if (!s_accept) begin
            cmd.op  = spq_pkg::OP_HOLD;
            n_count = r_count;
        end
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            spq_pkg::t_cell_pos pos;
            spq_pkg::t_entry    left_entry;
            logic               left_move;
            spq_pkg::t_entry    right_entry;

            assign pos.occ      = (spq_pkg::CNT_W'(i) < r_count);
            assign pos.at_free  = (spq_pkg::CNT_W'(i) == r_count);
            assign pos.hit      = (spq_pkg::CMP_W'(i) == slot_ext);
            assign pos.from_idx = (spq_pkg::CMP_W'(i) >= slot_ext);

            if (i == 0) begin : g_first
                assign left_entry = '0;
                assign left_move  = 1'b0;
            end else begin : g_mid
                assign left_entry = w_entry[i-1];
                assign left_move  = w_move[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign right_entry = w_entry[i];
            end else begin : g_inner
                assign right_entry = w_entry[i+1];
            end

            spq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (cmd),
                .i_pos         (pos),
                .i_left_entry  (left_entry),
                .i_left_move   (left_move),
                .i_right_entry (right_entry),
                .o_entry       (w_entry[i]),
                .o_next        (w_next[i]),
                .o_move        (w_move[i]),
                .o_hit_tag     (w_hit_tag[i])
            );
        end
    endgenerate

    always_comb begin
        hit_tag_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            hit_tag_or = hit_tag_or | w_hit_tag[k];
        end
    end

    assign removed_tag = (cmd.op == spq_pkg::OP_REMOVE) ? hit_tag_or : '0;
    assign head_valid  = (n_count != '0);
    assign head        = head_valid ? w_next[0] : '0;

    always_comb begin
        n_m_data        = '0;
        n_m_data[0]     = acc_flag;
        n_m_data[16:1]  = removed_tag;
        n_m_data[17]    = head_valid;
        n_m_data[33:18] = head.tag;
        n_m_data[36:34] = head.prio;
        n_m_data[41:37] = head.day;
        n_m_data[45:42] = head.month;
        n_m_data[57:46] = head.year;
        n_m_data[65:58] = spq_pkg::OUT_CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_year <= spq_pkg::MIN_YEAR_RST;
            r_count    <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_year <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (s_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// ----- sim/stable_priority_task_queue_tb.sv -----
// Self-checking testbench for stable_priority_task_queue: sorted insert, complete, peek, date check.
// Drives the stream ports with bursty traffic against a class-based prediction of the table.
// Depends on spq_pkg and the top level only.
`timescale 1ns / 1ps

import spq_pkg::*;

localparam int REQ_PAD_W = S_TDATA_W - (TAG_W + PRIO_W + DAY_W + MONTH_W + YEAR_W + SLOT_W);
localparam int RSP_PAD_W = M_TDATA_W - (2 * TAG_W + 2 + PRIO_W + DAY_W + MONTH_W + YEAR_W
                                        + OUT_CNT_W);

typedef struct packed {
    logic [REQ_PAD_W-1:0] pad;
    logic [SLOT_W-1:0]    slot;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [PRIO_W-1:0]    prio;
    logic [TAG_W-1:0]     tag;
} t_task_req;

typedef struct packed {
    logic [RSP_PAD_W-1:0] pad;
    logic [OUT_CNT_W-1:0] pending;
    logic [YEAR_W-1:0]    head_year;
    logic [MONTH_W-1:0]   head_month;
    logic [DAY_W-1:0]     head_day;
    logic [PRIO_W-1:0]    head_prio;
    logic [TAG_W-1:0]     head_tag;
    logic                 head_valid;
    logic [TAG_W-1:0]     removed_tag;
    logic                 accepted;
} t_task_rsp;

typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_BALANCED
} t_mix;

class task_table_scoreboard;
    t_entry            slots[QUEUE_DEPTH];
    int unsigned       fill;
    logic [YEAR_W-1:0] year_floor;
    t_task_rsp         expected_rsp[$];
    int unsigned       month_lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned       errors;
    int unsigned       results_checked;
    int unsigned       adds_stored;
    int unsigned       adds_refused;
    int unsigned       full_refusals;
    int unsigned       completes_done;
    int unsigned       completes_refused;
    int unsigned       other_ops;

    function new();
        fill = 0;
        year_floor = MIN_YEAR_RST;
        errors = 0;
        results_checked = 0;
        adds_stored = 0;
        adds_refused = 0;
        full_refusals = 0;
        completes_done = 0;
        completes_refused = 0;
        other_ops = 0;
    endfunction

    function int unsigned month_days(logic [MONTH_W-1:0] m, logic [YEAR_W-1:0] y);
        if (m == MONTH_FEB && y[1:0] == 2'b00) begin
            return 29;
        end
        return month_lengths[m - 4'd1];
    endfunction

    function bit due_date_valid(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] m,
                                logic [YEAR_W-1:0] y);
        if (y < year_floor || m == 4'd0 || m > MONTH_MAX) begin
            return 1'b0;
        end
        return 32'(d) <= month_days(m, y);
    endfunction

    function void note_request(t_action act, t_task_req req);
        t_task_rsp   rsp;
        int unsigned pos;
        rsp = '0;
        case (act)
            ACT_ADD: begin
                if (fill < QUEUE_DEPTH && req.prio >= PRIO_MIN && req.prio <= PRIO_MAX &&
                    due_date_valid(req.day, req.month, req.year)) begin
                    pos = fill;
                    while (pos > 0 && slots[pos-1].prio > req.prio) begin
                        slots[pos] = slots[pos-1];
                        pos--;
                    end
                    slots[pos].tag   = req.tag;
                    slots[pos].prio  = req.prio;
                    slots[pos].day   = req.day;
                    slots[pos].month = req.month;
                    slots[pos].year  = req.year;
                    fill++;
                    rsp.accepted = 1'b1;
                    adds_stored++;
                end else begin
                    adds_refused++;
                    if (fill == QUEUE_DEPTH) begin
                        full_refusals++;
                    end
                end
            end
            ACT_COMPLETE: begin
                if (32'(req.slot) < fill) begin
                    rsp.removed_tag = slots[req.slot].tag;
                    for (pos = req.slot; pos + 1 < fill; pos++) begin
                        slots[pos] = slots[pos+1];
                    end
                    fill--;
                    rsp.accepted = 1'b1;
                    completes_done++;
                end else begin
                    completes_refused++;
                end
            end
            ACT_PEEK: begin
                rsp.accepted = 1'b1;
                other_ops++;
            end
            default: begin
                other_ops++;
            end
        endcase
        if (fill > 0) begin
            rsp.head_valid = 1'b1;
            rsp.head_tag   = slots[0].tag;
            rsp.head_prio  = slots[0].prio;
            rsp.head_day   = slots[0].day;
            rsp.head_month = slots[0].month;
            rsp.head_year  = slots[0].year;
        end
        rsp.pending = OUT_CNT_W'(fill);
        expected_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] raw);
        t_task_rsp got;
        t_task_rsp want;
        got = raw;
        if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: result transaction with nothing expected: expected none, actual 0x%0h",
                     $time, raw);
            return;
        end
        want = expected_rsp.pop_front();
        results_checked++;
        compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
        compare_field("removed_tag", 32'(want.removed_tag), 32'(got.removed_tag));
        compare_field("head_valid", 32'(want.head_valid), 32'(got.head_valid));
        compare_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
        compare_field("head_priority", 32'(want.head_prio), 32'(got.head_prio));
        compare_field("head_day", 32'(want.head_day), 32'(got.head_day));
        compare_field("head_month", 32'(want.head_month), 32'(got.head_month));
        compare_field("head_year", 32'(want.head_year), 32'(got.head_year));
        compare_field("pending_count", 32'(want.pending), 32'(got.pending));
        compare_field("zero fill", 32'(want.pad), 32'(got.pad));
    endfunction
endclass

module stable_priority_task_queue_tb;

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [YEAR_W-1:0]      cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [S_TUSER_W-1:0]   s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    logic                   long_hold_req = 1'b0;
    int unsigned            long_holds = 0;
    int unsigned            floors_used = 1;
    task_table_scoreboard   sb;

    stable_priority_task_queue DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        forever begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    initial begin : receiver
        int unsigned tick;
        tick = 0;
        forever begin
            @(negedge clk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                long_holds++;
            end else begin
                tick++;
                case ((tick / 89) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 11) < 8);
                endcase
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_task_req make_req(logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                           logic [DAY_W-1:0] day, logic [MONTH_W-1:0] month,
                                           logic [YEAR_W-1:0] year, logic [SLOT_W-1:0] slot);
        t_task_req req;
        req.pad   = '0;
        req.tag   = tag;
        req.prio  = prio;
        req.day   = day;
        req.month = month;
        req.year  = year;
        req.slot  = slot;
        return req;
    endfunction

    task automatic drive_item(input t_action act, input t_task_req req);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(act, req);
    endtask

    task automatic hold_sender(input int unsigned cycles);
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_rsp.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_min_year(input logic [YEAR_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.year_floor = value;
        floors_used++;
    endtask

    function automatic void pick_item(input t_mix mix, output t_action act,
                                      output t_task_req req);
        logic [63:0]       raw;
        int unsigned       roll;
        int unsigned       add_pct;
        int unsigned       bad_pct;
        int unsigned       done_pct;
        int unsigned       lim;
        logic [MONTH_W-1:0] short_months[5];
        short_months = '{4'd2, 4'd4, 4'd6, 4'd9, 4'd11};
        raw = {$urandom, $urandom};
        req = raw[S_TDATA_W-1:0];
        req.pad = '0;
        case (mix)
            MIX_FILL:  begin add_pct = 88; bad_pct = 5;  done_pct = 4;  end
            MIX_DRAIN: begin add_pct = 15; bad_pct = 5;  done_pct = 72; end
            default:   begin add_pct = 40; bad_pct = 12; done_pct = 38; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < add_pct + bad_pct) begin
            act = ACT_ADD;
            req.prio  = PRIO_W'($urandom_range(1, 5));
            req.month = MONTH_W'($urandom_range(1, 12));
            req.year  = YEAR_W'($urandom_range(32'(sb.year_floor), 4095));
            req.day   = DAY_W'($urandom_range(0, sb.month_days(req.month, req.year)));
            if (roll >= add_pct) begin
                case ($urandom_range(0, 3))
                    0: req.prio = ($urandom_range(0, 1) == 0) ? 3'd0
                                                              : PRIO_W'($urandom_range(6, 7));
                    1: req.month = ($urandom_range(0, 1) == 0) ? 4'd0
                                                               : MONTH_W'($urandom_range(13, 15));
                    2: begin
                        req.month = short_months[$urandom_range(0, 4)];
                        lim = sb.month_days(req.month, req.year);
                        req.day = DAY_W'($urandom_range(lim + 1, 31));
                    end
                    default: begin
                        if (sb.year_floor != '0) begin
                            req.year = YEAR_W'($urandom_range(0, 32'(sb.year_floor) - 1));
                        end else begin
                            req.prio = 3'd7;
                        end
                    end
                endcase
            end
        end else if (roll < add_pct + bad_pct + done_pct) begin
            act = ACT_COMPLETE;
            if (sb.fill > 0 && $urandom_range(0, 9) < 8) begin
                req.slot = SLOT_W'($urandom_range(0, sb.fill - 1));
            end
        end else begin
            act = ($urandom_range(0, 2) == 0) ? ACT_NONE : ACT_PEEK;
        end
    endfunction

    task automatic run_traffic(input int unsigned count, input t_mix mix);
        int unsigned burst;
        int unsigned gap;
        t_action     act;
        t_task_req   req;
        burst = 0;
        repeat (count) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    hold_sender(gap);
                end
            end
            burst--;
            pick_item(mix, act, req);
            drive_item(act, req);
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        drive_item(ACT_PEEK,     make_req(16'h1234, 3'd3, 5'd1, 4'd1, 12'd2030, 7'd0));
        drive_item(ACT_COMPLETE, make_req(16'h0000, 3'd0, 5'd0, 4'd0, 12'd0, 7'd0));
        drive_item(ACT_NONE,     make_req(16'h5555, 3'd2, 5'd5, 4'd5, 12'd2025, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0101, 3'd0, 5'd10, 4'd3, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0202, 3'd6, 5'd10, 4'd3, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0303, 3'd7, 5'd10, 4'd3, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'hFFFF, 3'd5, 5'd31, 4'd12, 12'd4095, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0000, 3'd1, 5'd0, 4'd1, 12'd2024, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0A0A, 3'd3, 5'd15, 4'd6, 12'd2026, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0B0B, 3'd3, 5'd16, 4'd7, 12'd2027, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0C0C, 3'd1, 5'd20, 4'd8, 12'd2028, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h2828, 3'd2, 5'd29, 4'd2, 12'd2028, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h2525, 3'd2, 5'd29, 4'd2, 12'd2025, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h2424, 3'd4, 5'd28, 4'd2, 12'd2025, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0431, 3'd4, 5'd31, 4'd4, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h0430, 3'd5, 5'd30, 4'd4, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h1300, 3'd2, 5'd1, 4'd0, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h1313, 3'd2, 5'd1, 4'd13, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h1515, 3'd2, 5'd31, 4'd15, 12'd2030, 7'd0));
        drive_item(ACT_ADD,      make_req(16'h2023, 3'd2, 5'd1, 4'd1, 12'd2023, 7'd0));
        drive_item(ACT_COMPLETE, make_req(16'h0000, 3'd0, 5'd0, 4'd0, 12'd0, 7'd127));
        drive_item(ACT_COMPLETE, make_req(16'h0000, 3'd0, 5'd0, 4'd0, 12'd0,
                                          SLOT_W'(sb.fill - 1)));
        drive_item(ACT_COMPLETE, make_req(16'h0000, 3'd0, 5'd0, 4'd0, 12'd0, 7'd0));
        drive_item(ACT_PEEK,     make_req(16'hFFFF, 3'd7, 5'd31, 4'd15, 12'd4095, 7'd127));
        drive_item(ACT_NONE,     make_req(16'hFFFF, 3'd1, 5'd1, 4'd1, 12'd4095, 7'd0));

        write_min_year(12'd0);
        long_hold_req = 1'b1;
        run_traffic(170, MIX_FILL);
        run_traffic(200, MIX_DRAIN);

        write_min_year(12'hFFF);
        run_traffic(200, MIX_BALANCED);
        run_traffic(100, MIX_FILL);

        write_min_year(YEAR_W'($urandom_range(1, 4094)));
        long_hold_req = 1'b1;
        run_traffic(250, MIX_BALANCED);
        run_traffic(120, MIX_FILL);

        write_min_year(MIN_YEAR_RST);
        run_traffic(160, MIX_DRAIN);

        wait_drained();
        $display("Sent %0d adds (%0d stored, %0d refused, %0d on a full table), %0d completes",
                 sb.adds_stored + sb.adds_refused, sb.adds_stored, sb.adds_refused,
                 sb.full_refusals, sb.completes_done + sb.completes_refused);
        $display("(%0d refused), %0d peeks/no-ops; %0d results checked, %0d floors, %0d holds.",
                 sb.completes_refused, sb.other_ops, sb.results_checked, floors_used, long_holds);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/stable_priority_task_queue.sv
sim/stable_priority_task_queue_tb.sv
